/* rtl/core/header_block_checksum_deframer_assert.svh */
// Assertion macros shared by the checker.
`ifndef HEADER_BLOCK_CHECKSUM_DEFRAMER_ASSERT_SVH
`define HEADER_BLOCK_CHECKSUM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HBCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbcd assertion failed");

// Next-cycle implication, disabled during reset.
`define HBCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbcd assertion failed");

`endif

/* rtl/core/hbcd_pkg.sv */
package hbcd_pkg;

    localparam int unsigned HEADER_LEN = 4;
    localparam logic [7:0] HEADER_MARKER = 8'd255;
    localparam logic [7:0] DEFAULT_BLOCK_SIZE = 8'd64;
    localparam logic [7:0] SUM_ZERO_CODE = 8'd254;
    localparam logic [8:0] MOD_BASE = 9'd254;
    localparam logic [8:0] MOD_BASE_X2 = 9'd508;
    localparam logic [14:0] LINE_SCALE = 15'd100;
    // (100 * 100) + 100, removed from b0*100 + b1
    localparam logic [15:0] LINE_BIAS = 16'd10100;
    localparam logic [15:0] BLOCK_INDEX_MAX = 16'hFFFF;

    localparam int unsigned OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_OK     = 2'd2,
        KIND_ERR    = 2'd3
    } kind_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   data_byte;
        logic [7:0]   computed_sum;
        logic [14:0]  line_count;
        logic [7:0]   block_size;
        logic [15:0]  block_index;
    } result_t;

endpackage

/* rtl/core/header_block_checksum_deframer.sv */
// Header and block checksum deframer for a received byte stream.
// Input channel s_*: one item per received byte; s_tuser set means restart,
// which clears all framing state and produces no output item.
// The first four bytes form a header. A marker of 255 in byte 3 accepts it:
// line count and block size are latched and a header item goes out. Then
// each block is block_size data bytes (each passed out as a data item)
// followed by one check byte, reported as checksum ok or checksum error.
// Output channel m_*: m_tuser carries the item kind, m_tdata the payload.
// Config channel cfg_*: writes the default block size; always ready. Write
// it only while the block is idle; restart and a missing header marker
// reload the block size from it.
// Path: an accepted item goes into the input register, then its result into the
// result register, which drives m_tvalid. Throughput: one item per cycle; a new
// item is taken each cycle the input register is empty or its item can move on.
// Reset: both channels empty, default block size 64, framing state cleared.
// Receiver stall: the result register holds; the input register fills and
// then s_tready drops until m_tready returns.
module header_block_checksum_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [0:0]  s_tuser,    // [0] cmd (1 = restart)
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] computed_sum, [30:16] line_count,
    // [38:31] block_size, [54:39] block_index, [55] zero
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data    // [7:0] default_block_size
);

    logic [7:0]        default_size_reg;
    logic [7:0]        default_size_next;
    hbcd_pkg::item_t   s_item;
    hbcd_pkg::item_t   item;
    logic              item_valid;
    logic              out_free;
    logic              step;
    logic              res_valid;
    hbcd_pkg::result_t res;

    // Config writes are always taken.
    assign cfg_ready         = 1'b1;
    assign default_size_next = (cfg_valid && cfg_ready) ? cfg_data : default_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_size_reg <= hbcd_pkg::DEFAULT_BLOCK_SIZE;
        end
        else
        begin
            default_size_reg <= default_size_next;
        end
    end

    assign s_item.cmd     = s_tuser[0];
    assign s_item.rx_byte = s_tdata;

    // Advance the held item only when the result register can take its result.
    assign step = item_valid && out_free;

    hbcd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    hbcd_engine u_engine
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .item               (item),
        .default_block_size (default_size_reg),
        .res_valid          (res_valid),
        .res                (res)
    );

    hbcd_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/hbcd_in_stage.sv */
module hbcd_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  hbcd_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output hbcd_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    hbcd_pkg::item_t item_reg;

    // Take a new item whenever the register is empty or the held one leaves this cycle.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/hbcd_engine.sv */
module hbcd_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  hbcd_pkg::item_t   item,
    input  logic [7:0]        default_block_size,
    output logic              res_valid,
    output hbcd_pkg::result_t res
);

    localparam logic [2:0] HDR_DONE = 3'(hbcd_pkg::HEADER_LEN);
    localparam logic [2:0] HDR_LAST = 3'(hbcd_pkg::HEADER_LEN - 1);

    logic [2:0]  header_pos_reg, header_pos_next;
    logic [7:0]  hdr_reg [3];
    logic [14:0] line_count_reg, line_count_next;
    logic [7:0]  size_reg, size_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] blocks_reg, blocks_next;

    logic        hdr_wr;
    logic [8:0]  sum_wide;
    logic [8:0]  sum_mod;
    logic [7:0]  check_sum;
    logic [14:0] line_prod;
    logic [15:0] line_calc;

    assign sum_wide  = {1'b0, sum_reg} + {1'b0, item.rx_byte};
    assign check_sum = (sum_reg == 8'd0) ? hbcd_pkg::SUM_ZERO_CODE : sum_reg;
    assign line_prod = 15'(hdr_reg[0]) * hbcd_pkg::LINE_SCALE;
    assign line_calc = 16'(line_prod) + 16'(hdr_reg[1]) - hbcd_pkg::LINE_BIAS;

    always_comb
    begin
        priority if (sum_wide >= hbcd_pkg::MOD_BASE_X2)
        begin
            sum_mod = sum_wide - hbcd_pkg::MOD_BASE_X2;
        end
        else if (sum_wide >= hbcd_pkg::MOD_BASE)
        begin
            sum_mod = sum_wide - hbcd_pkg::MOD_BASE;
        end
        else
        begin
            sum_mod = sum_wide;
        end
    end

    always_comb
    begin
        header_pos_next = header_pos_reg;
        line_count_next = line_count_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        blocks_next     = blocks_reg;
        hdr_wr          = 1'b0;
        res_valid       = 1'b0;
        res.kind        = hbcd_pkg::KIND_DATA;
        res.data_byte   = 8'd0;
        res.computed_sum = 8'd0;
        res.block_index = blocks_reg;

        priority if (item.cmd)
        begin
            header_pos_next = 3'd0;
            line_count_next = 15'd0;
            size_next       = default_block_size;
            pos_next        = 8'd0;
            sum_next        = 8'd0;
            blocks_next     = 16'd0;
        end
        else if (header_pos_reg < HDR_DONE)
        begin
            hdr_wr          = (header_pos_reg < HDR_LAST);
            header_pos_next = header_pos_reg + 3'd1;
            if (header_pos_reg == HDR_LAST)
            begin
                if (item.rx_byte == hbcd_pkg::HEADER_MARKER)
                begin
                    size_next       = hdr_reg[2];
                    line_count_next = line_calc[14:0];
                    res_valid       = 1'b1;
                    res.kind        = hbcd_pkg::KIND_HEADER;
                end
                else
                begin
                    size_next = default_block_size;
                end
            end
        end
        else if (pos_reg < size_reg)
        begin
            sum_next      = sum_mod[7:0];
            pos_next      = pos_reg + 8'd1;
            res_valid     = 1'b1;
            res.kind      = hbcd_pkg::KIND_DATA;
            res.data_byte = item.rx_byte;
        end
        else
        begin
            res_valid        = 1'b1;
            res.kind         = (check_sum == item.rx_byte) ? hbcd_pkg::KIND_OK
                                                          : hbcd_pkg::KIND_ERR;
            res.data_byte    = item.rx_byte;
            res.computed_sum = check_sum;
            pos_next         = 8'd0;
            sum_next         = 8'd0;
            if (blocks_reg != hbcd_pkg::BLOCK_INDEX_MAX)
            begin
                blocks_next = blocks_reg + 16'd1;
            end
        end

        res.line_count = line_count_next;
        res.block_size = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg <= 3'd0;
            line_count_reg <= 15'd0;
            size_reg       <= hbcd_pkg::DEFAULT_BLOCK_SIZE;
            pos_reg        <= 8'd0;
            sum_reg        <= 8'd0;
            blocks_reg     <= 16'd0;
        end
        else if (step)
        begin
            header_pos_reg <= header_pos_next;
            line_count_reg <= line_count_next;
            size_reg       <= size_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            blocks_reg     <= blocks_next;
        end
    end

    // Header bytes are read only after the header pass wrote them.
    always_ff @(posedge clk)
    begin
        if (step && !item.cmd && hdr_wr)
        begin
            hdr_reg[header_pos_reg[1:0]] <= item.rx_byte;
        end
    end

endmodule

/* rtl/core/hbcd_out_stage.sv */
module hbcd_out_stage
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  hbcd_pkg::result_t                    res,
    output logic                                 free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hbcd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                           m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    hbcd_pkg::result_t res_reg;

    // Free when empty or the held item leaves this cycle.
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {1'b0, res_reg.block_index, res_reg.block_size,
                       res_reg.line_count, res_reg.computed_sum, res_reg.data_byte};

endmodule

/* rtl/core/hbcd_checker.sv */
`include "header_block_checksum_deframer_assert.svh"

module hbcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled output item holds its payload.
    `HBCD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A draining receiver never blocks the input side.
    `HBCD_ASSERT_NOW(a_no_bubble, clk, rst_n, m_tready, s_tready)

    // Header and data items carry no checksum.
    `HBCD_ASSERT_NOW(a_no_sum, clk, rst_n, m_tvalid && (m_tuser == hbcd_pkg::KIND_HEADER || m_tuser == hbcd_pkg::KIND_DATA), m_tdata[15:8] == 8'd0)

    // Check verdict agrees with the reported sums.
    `HBCD_ASSERT_NOW(a_verdict, clk, rst_n, m_tvalid && (m_tuser == hbcd_pkg::KIND_OK || m_tuser == hbcd_pkg::KIND_ERR), m_tdata[15:8] != 8'd0 && ((m_tuser == hbcd_pkg::KIND_OK) == (m_tdata[15:8] == m_tdata[7:0])))

endmodule

bind header_block_checksum_deframer hbcd_checker u_hbcd_checker (.*);

/* tb/sv/hbcd_frame_checker.sv */
`timescale 1ns / 100ps

module hbcd_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [0:0]  s_tuser,    // [0] cmd (1 = restart)
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] computed_sum, [30:16] line_count,
    // [38:31] block_size, [54:39] block_index, [55] zero
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,   // [7:0] default_block_size
    output int          mismatches,
    output int          outstanding
);

    logic [2:0]        hdr_pos;
    logic [7:0]        hdr_byte [3];
    logic              hdr_taken;
    logic [7:0]        reg_size;
    logic [7:0]        size_now;
    logic [7:0]        fill;
    logic [7:0]        sum_mod;
    logic [15:0]       blocks_seen;
    hbcd_pkg::result_t due_results [$];

    task automatic clear_frame();
        hdr_pos     = '0;
        hdr_byte[0] = '0;
        hdr_byte[1] = '0;
        hdr_byte[2] = '0;
        hdr_taken   = 1'b0;
        size_now    = reg_size;
        fill        = '0;
        sum_mod     = '0;
        blocks_seen = '0;
    endtask

    function automatic logic [14:0] lines_now();
        int lc;
        lc = (int'(hdr_byte[0]) - 100) * 100 + (int'(hdr_byte[1]) - 100);
        return hdr_taken ? lc[14:0] : 15'd0;
    endfunction

    // Advance the framing state by one received item and queue the result it causes, if any.
    task automatic absorb_byte(input logic restart, input logic [7:0] b);
        hbcd_pkg::result_t r;
        logic [7:0]        s;
        r = '0;
        if (restart) begin
            clear_frame();
            return;
        end
        if (hdr_pos < hbcd_pkg::HEADER_LEN) begin
            if (hdr_pos < 3)
                hdr_byte[hdr_pos] = b;
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos < hbcd_pkg::HEADER_LEN)
                return;
            if (b != hbcd_pkg::HEADER_MARKER) begin
                size_now = reg_size;
                return;
            end
            hdr_taken = 1'b1;
            size_now  = hdr_byte[2];
            r.kind    = hbcd_pkg::KIND_HEADER;
        end
        else if (fill < size_now) begin
            sum_mod     = 8'((int'(sum_mod) + int'(b)) % int'(hbcd_pkg::MOD_BASE));
            fill        = fill + 8'd1;
            r.kind      = hbcd_pkg::KIND_DATA;
            r.data_byte = b;
        end
        else begin
            s              = (sum_mod == 0) ? hbcd_pkg::SUM_ZERO_CODE : sum_mod;
            r.kind         = (s == b) ? hbcd_pkg::KIND_OK : hbcd_pkg::KIND_ERR;
            r.data_byte    = b;
            r.computed_sum = s;
        end
        r.block_index = blocks_seen;
        r.line_count  = lines_now();
        r.block_size  = size_now;
        if (r.kind == hbcd_pkg::KIND_OK || r.kind == hbcd_pkg::KIND_ERR) begin
            if (blocks_seen != hbcd_pkg::BLOCK_INDEX_MAX)
                blocks_seen = blocks_seen + 16'd1;
            fill    = '0;
            sum_mod = '0;
        end
        due_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hbcd_pkg::result_t want;
        if (!rst_n) begin
            reg_size = hbcd_pkg::DEFAULT_BLOCK_SIZE;
            clear_frame();
            due_results.delete();
            mismatches = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                reg_size = cfg_data;
            if (s_tvalid && s_tready)
                absorb_byte(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: kind %0d tdata %0h, none pending",
                                 m_tuser, m_tdata);
                    mismatches++;
                end
                else begin
                    want = due_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_tuser));
                    check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
                    check_field("computed_sum", 16'(want.computed_sum), 16'(m_tdata[15:8]));
                    check_field("line_count", 16'(want.line_count), 16'(m_tdata[30:16]));
                    check_field("block_size", 16'(want.block_size), 16'(m_tdata[38:31]));
                    check_field("block_index", want.block_index, m_tdata[54:39]);
                end
            end
        end
        outstanding = due_results.size();
    end

endmodule

/* tb/sv/tb_header_block_checksum_deframer.sv */
`timescale 1ns / 100ps

module tb_header_block_checksum_deframer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] rx_byte
    logic [0:0]  s_tuser = '0;     // [0] cmd (1 = restart)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] data_byte, [15:8] computed_sum, [30:16] line_count,
    // [38:31] block_size, [54:39] block_index, [55] zero
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;          // [1:0] kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;    // [7:0] default_block_size

    int mismatches;
    int outstanding;

    // Stall odds per side, in percent; zero gives a stretch with no idling.
    int s_idle_pct = 33;
    int m_idle_pct = 33;
    // Remaining cycles of a forced receiver hold-off.
    int hold_cycles = 0;
    int items_sent = 0;
    // Stimulus-side view of the block size, used to shape well-formed blocks.
    logic [7:0] dflt_size = hbcd_pkg::DEFAULT_BLOCK_SIZE;
    int frame_len = hbcd_pkg::DEFAULT_BLOCK_SIZE;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    header_block_checksum_deframer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hbcd_frame_checker frame_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: drop ready at random, or hold it low for the whole of a
    // forced hold-off so the input side backs up and stalls.
    always @(negedge clk)
    begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else begin
            m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Offer one item from a falling edge; return at the falling edge after
    // it was taken, with valid still high so back-to-back items stay packed.
    task automatic send_item(input logic restart, input logic [7:0] b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Send the four header bytes and track which block size takes effect.
    task automatic send_header(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3);
        send_item(1'b0, b0);
        send_item(1'b0, b1);
        send_item(1'b0, b2);
        send_item(1'b0, b3);
        frame_len = (b3 == hbcd_pkg::HEADER_MARKER) ? b2 : dflt_size;
    endtask

    // Send one full block of random data; corrupt the check byte unless good.
    task automatic send_block(input bit good);
        int         sum;
        logic [7:0] b;
        logic [7:0] chk;
        sum = 0;
        for (int i = 0; i < frame_len; i++) begin
            b   = 8'($urandom);
            sum = (sum + b) % int'(hbcd_pkg::MOD_BASE);
            send_item(1'b0, b);
        end
        chk = (sum == 0) ? hbcd_pkg::SUM_ZERO_CODE : 8'(sum);
        if (!good)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_item(1'b0, chk);
    endtask

    // Drain the block completely, then write the default block size.
    task automatic write_default_size(input logic [7:0] v);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        // Keep waiting after that: header bytes and restarts make no result
        // but may still sit in the two-stage pipeline.
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        dflt_size = v;
    endtask

    // Mostly well-formed frames with random content: restart, header, a few
    // blocks. Mix in cut-off headers, corrupted check bytes and trailing junk.
    task automatic run_frames(input int budget);
        int         stop_at;
        int         n_blocks;
        int         pick;
        logic [7:0] b2;
        logic [7:0] marker;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            send_item(1'b1, 8'($urandom));
            if ($urandom_range(99) < 10) begin
                // cut the header short; the next pass restarts
                repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
                continue;
            end
            pick   = $urandom_range(99);
            b2     = (pick < 5) ? 8'($urandom_range(100, 255)) :
                     (pick < 15) ? 8'd0 : 8'($urandom_range(1, 8));
            marker = ($urandom_range(99) < 85) ? hbcd_pkg::HEADER_MARKER
                                               : 8'($urandom_range(0, 254));
            send_header(8'($urandom), 8'($urandom), b2, marker);
            // keep long blocks rare so the run stays short
            n_blocks = (frame_len > 32) ? 1 : $urandom_range(1, 8);
            repeat (n_blocks) send_block($urandom_range(99) < 70);
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, frame_len + 1)) send_item(1'b0, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: marker header with the largest line count, a block whose
        // sum wraps to zero, a corrupted block, restart with a byte set.
        send_header(8'd255, 8'd255, 8'd2, hbcd_pkg::HEADER_MARKER);
        send_item(1'b0, 8'd127);
        send_item(1'b0, 8'd127);
        send_item(1'b0, hbcd_pkg::SUM_ZERO_CODE);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd7);
        send_item(1'b1, 8'd255);
        // Smallest line count and a zero block size: every byte is a check byte.
        send_header(8'd0, 8'd0, 8'd0, hbcd_pkg::HEADER_MARKER);
        send_item(1'b0, hbcd_pkg::SUM_ZERO_CODE);
        send_item(1'b0, 8'd0);
        send_item(1'b1, 8'd0);
        // No marker: the reset default size applies and no header item goes out.
        send_header(8'd1, 8'd2, 8'd3, 8'd4);
        send_item(1'b0, 8'h5a);

        // Random frames under a range of default sizes, extremes included.
        write_default_size(8'd255);
        run_frames(200);
        write_default_size(8'd0);
        run_frames(250);
        write_default_size(8'd1);
        // hold off the receiver while the sender keeps offering items
        hold_cycles = 400;
        run_frames(300);
        write_default_size(8'd3);
        run_frames(300);
        s_idle_pct = 0;
        m_idle_pct = 0;
        write_default_size(8'($urandom_range(2, 20)));
        run_frames(250);
        s_idle_pct = 33;
        m_idle_pct = 33;
        write_default_size(8'($urandom));
        run_frames(300);

        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        // let any stray result surface before the verdict
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
